// ===== design/imusfp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// imusfp_pkg
// Shared types and constants of the IMU serial frame parser.
// ---------------------------------------------------------------------------
package imusfp_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH           = 16;
   localparam int SEEN_WIDTH            = 32;
   localparam int CSR_INDEX_WIDTH       = 3;
   localparam int CSR_DATA_WIDTH        = 8;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_KIND = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_KIND  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_KIND = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUAT_KIND  = 3'd4;

   // register reset values
   localparam logic [7:0] SYNC_RESET       = 8'h55;
   localparam logic [7:0] ACCEL_KIND_RESET = 8'h51;
   localparam logic [7:0] RATE_KIND_RESET  = 8'h52;
   localparam logic [7:0] ANGLE_KIND_RESET = 8'h53;
   localparam logic [7:0] QUAT_KIND_RESET  = 8'h59;

   // result groups
   localparam logic [1:0] GROUP_ACCEL = 2'd0;
   localparam logic [1:0] GROUP_RATE  = 2'd1;
   localparam logic [1:0] GROUP_ANGLE = 2'd2;
   localparam logic [1:0] GROUP_QUAT  = 2'd3;

   // good frame handed from the parser to the record stage
   typedef struct packed {
      logic [1:0]                  group;
      logic [3:0][FIELD_WIDTH-1:0] words;
   } frame_cmd_type;

endpackage
`default_nettype wire

// ===== design/imusfp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// imusfp_front
// Byte parser: sync hunt, frame assembly, checksum and kind decode.
// ---------------------------------------------------------------------------
module imusfp_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_rx_byte,
   input  wire logic                                  csr_wr_en,
   input  wire logic [imusfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [imusfp_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic                                       cmd_push,
   output imusfp_pkg::frame_cmd_type                  cmd_data,
   input  wire logic                                  cmd_full
);
   import imusfp_pkg::*;

   localparam logic [3:0] POS_HUNT  = 4'd0;
   localparam logic [3:0] POS_KIND  = 4'd1;
   localparam logic [3:0] POS_CHECK = 4'd10;
   localparam logic [3:0] FRAME_LEN = 4'd11;

   logic [7:0] sync_ff, accel_kind_ff, rate_kind_ff, angle_kind_ff, quat_kind_ff;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] payload_ff [8];
   logic       accept;
   logic       pay_wr;
   logic [3:0] pos_m2;
   logic       good;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= SYNC_RESET;
         accel_kind_ff <= ACCEL_KIND_RESET;
         rate_kind_ff  <= RATE_KIND_RESET;
         angle_kind_ff <= ANGLE_KIND_RESET;
         quat_kind_ff  <= QUAT_KIND_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC:       sync_ff       <= csr_data;
            CSR_ACCEL_KIND: accel_kind_ff <= csr_data;
            CSR_RATE_KIND:  rate_kind_ff  <= csr_data;
            CSR_ANGLE_KIND: angle_kind_ff <= csr_data;
            CSR_QUAT_KIND:  quat_kind_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = (pos_ff != POS_CHECK) || !cmd_full;
   assign accept    = req_valid && req_ready;
   assign pos_m2    = pos_ff - 4'd2;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      kind_in  = kind_ff;
      pay_wr   = 1'b0;
      good     = 1'b0;
      if (pos_ff == POS_HUNT || pos_ff >= FRAME_LEN) begin
         if (req_rx_byte == sync_ff) begin
            sum_in = req_rx_byte;
            pos_in = POS_KIND;
         end else begin
            pos_in = POS_HUNT;
         end
      end else if (pos_ff == POS_KIND) begin
         kind_in = req_rx_byte;
         sum_in  = sum_ff + req_rx_byte;
         pos_in  = pos_ff + 4'd1;
      end else if (pos_ff < POS_CHECK) begin
         pay_wr = 1'b1;
         sum_in = sum_ff + req_rx_byte;
         pos_in = pos_ff + 4'd1;
      end else begin
         pos_in = POS_HUNT;
         good   = (sum_ff == req_rx_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_HUNT;
         sum_ff  <= 8'd0;
         kind_ff <= 8'd0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pay_wr) begin
         payload_ff[pos_m2[2:0]] <= req_rx_byte;
      end
   end

   always_comb begin
      cmd_data.group = GROUP_ACCEL;
      for (int k = 0; k < 4; k++) begin
         cmd_data.words[k] = {payload_ff[2*k+1], payload_ff[2*k]};
      end
      cmd_push = 1'b0;
      if (accept && good) begin
         if (kind_ff == accel_kind_ff) begin
            cmd_data.group = GROUP_ACCEL;
            cmd_push       = 1'b1;
         end else if (kind_ff == rate_kind_ff) begin
            cmd_data.group = GROUP_RATE;
            cmd_push       = 1'b1;
         end else if (kind_ff == angle_kind_ff) begin
            cmd_data.group = GROUP_ANGLE;
            cmd_push       = 1'b1;
         end else if (kind_ff == quat_kind_ff) begin
            cmd_data.group = GROUP_QUAT;
            cmd_push       = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/imusfp_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// imusfp_queue
// Two-entry queue of good frames between parser and record stage.
// ---------------------------------------------------------------------------
module imusfp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire imusfp_pkg::frame_cmd_type push_data,
   output logic                           full,
   output logic                           pop_valid,
   input  wire logic                      pop,
   output imusfp_pkg::frame_cmd_type      pop_data
);
   import imusfp_pkg::*;

   frame_cmd_type entry_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule
`default_nettype wire

// ===== design/imusfp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// imusfp_back
// Record stage: stores values, counts frames, plays out the record.
// ---------------------------------------------------------------------------
module imusfp_back #(
   parameter int COUNTER_WIDTH = imusfp_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  cmd_valid,
   output logic                                       cmd_pop,
   input  wire imusfp_pkg::frame_cmd_type             cmd_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_group,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_a,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_b,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_c,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_d,
   output logic [imusfp_pkg::SEEN_WIDTH-1:0]          rsp_frames_seen,
   output logic                                       rsp_last
);
   import imusfp_pkg::*;

   logic [2:0][FIELD_WIDTH-1:0]   accel_ff, rate_ff, angle_ff;
   logic [3:0][FIELD_WIDTH-1:0]   quat_ff;
   logic [2:0][COUNTER_WIDTH-1:0] cnt_ff;
   logic                          busy_ff;
   logic [1:0]                    idx_ff;
   logic                          out_free;
   logic                          emit;

   logic                                 rsp_valid_ff;
   logic [1:0]                           group_ff;
   logic [FIELD_WIDTH-1:0]               a_ff, b_ff, c_ff, d_ff;
   logic [SEEN_WIDTH-1:0]                seen_ff;
   logic                                 last_ff;
   logic [2:0][FIELD_WIDTH-1:0]          sel_abc;
   logic [FIELD_WIDTH-1:0]               d_in;
   logic [SEEN_WIDTH-1:0]                seen_in;
   logic [COUNTER_WIDTH+SEEN_WIDTH-1:0]  seen_wide;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign cmd_pop  = cmd_valid && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= '0;
         rate_ff  <= '0;
         angle_ff <= '0;
         quat_ff  <= '0;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (cmd_pop) begin
            case (cmd_data.group)
               GROUP_ACCEL: begin
                  accel_ff  <= cmd_data.words[2:0];
                  cnt_ff[0] <= cnt_ff[0] + COUNTER_WIDTH'(1);
               end
               GROUP_RATE: begin
                  rate_ff   <= cmd_data.words[2:0];
                  cnt_ff[1] <= cnt_ff[1] + COUNTER_WIDTH'(1);
               end
               GROUP_ANGLE: begin
                  angle_ff  <= cmd_data.words[2:0];
                  cnt_ff[2] <= cnt_ff[2] + COUNTER_WIDTH'(1);
               end
               default: begin
                  quat_ff <= cmd_data.words;
                  busy_ff <= 1'b1;
                  idx_ff  <= GROUP_ACCEL;
               end
            endcase
         end
         if (emit) begin
            idx_ff <= idx_ff + 2'd1;
            if (idx_ff == GROUP_QUAT) busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      d_in      = '0;
      seen_wide = '0;
      case (idx_ff)
         GROUP_ACCEL: begin
            sel_abc   = accel_ff;
            seen_wide = {{SEEN_WIDTH{1'b0}}, cnt_ff[0]};
         end
         GROUP_RATE: begin
            sel_abc   = rate_ff;
            seen_wide = {{SEEN_WIDTH{1'b0}}, cnt_ff[1]};
         end
         GROUP_ANGLE: begin
            sel_abc   = angle_ff;
            seen_wide = {{SEEN_WIDTH{1'b0}}, cnt_ff[2]};
         end
         default: begin
            sel_abc = quat_ff[2:0];
            d_in    = quat_ff[3];
         end
      endcase
      seen_in = seen_wide[SEEN_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         group_ff <= idx_ff;
         a_ff     <= sel_abc[0];
         b_ff     <= sel_abc[1];
         c_ff     <= sel_abc[2];
         d_ff     <= d_in;
         seen_ff  <= seen_in;
         last_ff  <= (idx_ff == GROUP_QUAT);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group       = group_ff;
   assign rsp_value_a     = $signed(a_ff);
   assign rsp_value_b     = $signed(b_ff);
   assign rsp_value_c     = $signed(c_ff);
   assign rsp_value_d     = $signed(d_ff);
   assign rsp_frames_seen = seen_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// ===== design/imu_serial_frame_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// imu_serial_frame_parser
// Parses 11-byte IMU frames from a serial byte stream and plays out the
// stored record as four words on every good quaternion frame.
//
//   channel   direction  ports
//   req       in         req_valid / req_ready, req_rx_byte
//   rsp       out        rsp_valid / rsp_ready, rsp_group .. rsp_last
//   csr       in         csr_wr_en, csr_index, csr_data (write only)
//
// One byte per cycle; the parser stalls only on a checksum byte when the
// two-entry frame queue is full. A quaternion frame holds the record stage
// busy while it is taken from the queue and its four result words are
// played out, paced by the output register. Other frames leave it free.
// Synchronous reset clears control state, counters, stored values and
// restores register defaults. No clearing pass after reset.
// ---------------------------------------------------------------------------
module imu_serial_frame_parser #(
   parameter int COUNTER_WIDTH = imusfp_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_rx_byte,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_group,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_a,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_b,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_c,
   output logic signed [imusfp_pkg::FIELD_WIDTH-1:0]  rsp_value_d,
   output logic [imusfp_pkg::SEEN_WIDTH-1:0]          rsp_frames_seen,
   output logic                                       rsp_last,
   input  wire logic                                  csr_wr_en,
   input  wire logic [imusfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [imusfp_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import imusfp_pkg::*;

   logic          push, full, q_valid, q_pop;
   frame_cmd_type push_data, q_data;

   imusfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd_push    (push),
      .cmd_data    (push_data),
      .cmd_full    (full)
   );

   imusfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   imusfp_back #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_valid),
      .cmd_pop         (q_pop),
      .cmd_data        (q_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_group       (rsp_group),
      .rsp_value_a     (rsp_value_a),
      .rsp_value_b     (rsp_value_b),
      .rsp_value_c     (rsp_value_c),
      .rsp_value_d     (rsp_value_d),
      .rsp_frames_seen (rsp_frames_seen),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Checks the IMU serial frame parser byte by byte. A frame model tracks the
// sync hunt, the running checksum, the stored groups and the per-kind frame
// counts. It predicts the four record words of every good quaternion frame
// and compares them field by field with the rsp words, in order. Stimulus
// covers value extremes, bad checksums, sync bytes inside frames, unknown
// and shared kinds, out-of-range register writes, and random traffic under
// several register settings. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
   import imusfp_pkg::*;

   localparam int FRAME_BYTES   = 11;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BYTES   = 6;
   localparam int MAX_REPORTS   = 30;
   localparam int TIMEOUT       = 12 * 400000;

   typedef struct packed {
      logic [1:0]  group;
      logic [15:0] value_a;
      logic [15:0] value_b;
      logic [15:0] value_c;
      logic [15:0] value_d;
      logic [31:0] frames_seen;
      logic        last;
   } record_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_group;
   logic [15:0] rsp_value_a;
   logic [15:0] rsp_value_b;
   logic [15:0] rsp_value_c;
   logic [15:0] rsp_value_d;
   logic [31:0] rsp_frames_seen;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   // frame model
   logic [7:0]  cfg_reg [5];
   logic [3:0]  frame_pos;
   logic [7:0]  frame_sum;
   logic [7:0]  frame_kind;
   logic [7:0]  payload [8];
   logic [15:0] stored_vals [4][4];
   logic [31:0] good_count [3];

   record_word_type expected_words [$];
   record_word_type oldest_word;

   int  errors;
   int  words_predicted;
   int  words_checked;
   int  bytes_sent;
   int  frames_sent;
   int  quat_frames_sent;
   int  stall_left;
   bit  quiet_mode;

   imu_serial_frame_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_group       (rsp_group),
      .rsp_value_a     (rsp_value_a),
      .rsp_value_b     (rsp_value_b),
      .rsp_value_c     (rsp_value_c),
      .rsp_value_d     (rsp_value_d),
      .rsp_frames_seen (rsp_frames_seen),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT);
      $display("FAILURE");
      $finish;
   end

   task report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
   endtask

   task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 20);
   endfunction

   function void reset_model();
      cfg_reg[CSR_SYNC]       = SYNC_RESET;
      cfg_reg[CSR_ACCEL_KIND] = ACCEL_KIND_RESET;
      cfg_reg[CSR_RATE_KIND]  = RATE_KIND_RESET;
      cfg_reg[CSR_ANGLE_KIND] = ANGLE_KIND_RESET;
      cfg_reg[CSR_QUAT_KIND]  = QUAT_KIND_RESET;
      frame_pos  = '0;
      frame_sum  = '0;
      frame_kind = '0;
      for (int i = 0; i < 8; i++) begin
         payload[i] = '0;
      end
      for (int g = 0; g < 4; g++) begin
         for (int k = 0; k < 4; k++) begin
            stored_vals[g][k] = '0;
         end
      end
      for (int g = 0; g < 3; g++) begin
         good_count[g] = '0;
      end
   endfunction

   function void store_group(input logic [1:0] grp);
      for (int k = 0; k < 4; k++) begin
         stored_vals[grp][k] = {payload[2*k+1], payload[2*k]};
      end
      if (grp != GROUP_QUAT) begin
         good_count[grp] = good_count[grp] + 32'd1;
      end
   endfunction

   function void push_record();
      record_word_type w;
      for (int g = 0; g < 4; g++) begin
         w.group   = g[1:0];
         w.value_a = stored_vals[g][0];
         w.value_b = stored_vals[g][1];
         w.value_c = stored_vals[g][2];
         if (g[1:0] == GROUP_QUAT) begin
            w.value_d     = stored_vals[g][3];
            w.frames_seen = '0;
            w.last        = 1'b1;
         end else begin
            w.value_d     = '0;
            w.frames_seen = good_count[g];
            w.last        = 1'b0;
         end
         expected_words.push_back(w);
         words_predicted++;
      end
   endfunction

   function void close_frame();
      if (frame_kind == cfg_reg[CSR_ACCEL_KIND]) begin
         store_group(GROUP_ACCEL);
      end else if (frame_kind == cfg_reg[CSR_RATE_KIND]) begin
         store_group(GROUP_RATE);
      end else if (frame_kind == cfg_reg[CSR_ANGLE_KIND]) begin
         store_group(GROUP_ANGLE);
      end else if (frame_kind == cfg_reg[CSR_QUAT_KIND]) begin
         store_group(GROUP_QUAT);
         push_record();
      end
   endfunction

   function void parse_byte(input logic [7:0] b);
      logic [3:0] slot;
      slot = frame_pos - 4'd2;
      if (frame_pos == 4'd0 || frame_pos >= FRAME_BYTES) begin
         if (b == cfg_reg[CSR_SYNC]) begin
            frame_sum = b;
            frame_pos = 4'd1;
         end else begin
            frame_pos = 4'd0;
         end
      end else if (frame_pos == 4'd1) begin
         frame_kind = b;
         frame_sum  = frame_sum + b;
         frame_pos  = 4'd2;
      end else if (frame_pos < FRAME_BYTES - 1) begin
         payload[slot[2:0]] = b;
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 4'd1;
      end else begin
         frame_pos = 4'd0;
         if (frame_sum == b) begin
            close_frame();
         end
      end
   endfunction

   // model update and result check, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en && csr_index <= CSR_QUAT_KIND) begin
            cfg_reg[csr_index] = csr_data;
         end
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               report_mismatch("result word with none expected");
            end else begin
               oldest_word = expected_words.pop_front();
               compare_field("group", 32'(rsp_group), 32'(oldest_word.group));
               compare_field("value_a", 32'(rsp_value_a), 32'(oldest_word.value_a));
               compare_field("value_b", 32'(rsp_value_b), 32'(oldest_word.value_b));
               compare_field("value_c", 32'(rsp_value_c), 32'(oldest_word.value_c));
               compare_field("value_d", 32'(rsp_value_d), 32'(oldest_word.value_d));
               compare_field("frames_seen", rsp_frames_seen, oldest_word.frames_seen);
               compare_field("last", 32'(rsp_last), 32'(oldest_word.last));
            end
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
         end
      end
   end

   task send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task send_frame(input logic [7:0] kind, input logic [3:0][15:0] words,
                   input logic [7:0] sum_delta, input int cut);
      logic [7:0] octets [FRAME_BYTES];
      logic [7:0] sum;
      octets[0] = cfg_reg[CSR_SYNC];
      octets[1] = kind;
      for (int k = 0; k < 4; k++) begin
         octets[2+2*k] = words[k][7:0];
         octets[3+2*k] = words[k][15:8];
      end
      sum = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         sum = sum + octets[i];
      end
      octets[FRAME_BYTES-1] = sum + sum_delta;
      for (int i = 0; i < cut; i++) begin
         send_byte(octets[i]);
      end
      bytes_sent += cut;
      if (cut == FRAME_BYTES) begin
         frames_sent++;
         if (kind == cfg_reg[CSR_QUAT_KIND]) begin
            quat_frames_sent++;
         end
      end
   endtask

   task good_frame(input logic [7:0] kind, input logic [15:0] a, input logic [15:0] b,
                   input logic [15:0] c, input logic [15:0] d);
      send_frame(kind, {d, c, b, a}, 8'h00, FRAME_BYTES);
   endtask

   task settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task load_registers(input logic [7:0] sync, input logic [7:0] accel,
                       input logic [7:0] rate, input logic [7:0] angle,
                       input logic [7:0] quat);
      settle();
      csr_write(CSR_SYNC, sync);
      csr_write(CSR_ACCEL_KIND, accel);
      csr_write(CSR_RATE_KIND, rate);
      csr_write(CSR_ANGLE_KIND, angle);
      csr_write(CSR_QUAT_KIND, quat);
   endtask

   task load_defaults();
      load_registers(SYNC_RESET, ACCEL_KIND_RESET, RATE_KIND_RESET, ANGLE_KIND_RESET,
                     QUAT_KIND_RESET);
   endtask

   // noise while hunting, then a record straight out of reset
   task test_reset_record();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_RESET - 8'd1);
      send_byte(SYNC_RESET + 8'd1);
      good_frame(cfg_reg[CSR_QUAT_KIND], 16'h1234, 16'hFEDC, 16'h0001, 16'h8001);
   endtask

   task test_value_extremes();
      good_frame(cfg_reg[CSR_ACCEL_KIND], 16'h7FFF, 16'h8000, 16'hFFFF, 16'hAAAA);
      good_frame(cfg_reg[CSR_RATE_KIND], 16'h0000, 16'h0001, 16'hFFFF, 16'h5555);
      good_frame(cfg_reg[CSR_ANGLE_KIND], 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      good_frame(cfg_reg[CSR_QUAT_KIND], 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
   endtask

   // sync value inside the payload is plain data
   task test_sync_in_frame();
      logic [15:0] twin;
      twin = {cfg_reg[CSR_SYNC], cfg_reg[CSR_SYNC]};
      good_frame(cfg_reg[CSR_ANGLE_KIND], twin, twin, twin, twin);
      good_frame(cfg_reg[CSR_QUAT_KIND], twin, 16'h0000, twin, 16'h00FF);
   endtask

   // dropped frames store and count nothing; hunting resumes on the next byte
   task test_bad_checksum();
      good_frame(cfg_reg[CSR_ACCEL_KIND], 16'h0102, 16'h0304, 16'h0506, 16'h0708);
      send_frame(cfg_reg[CSR_ACCEL_KIND], {4{16'h4444}}, 8'h01, FRAME_BYTES);
      send_frame(cfg_reg[CSR_QUAT_KIND], {4{16'h3333}}, 8'hFF, FRAME_BYTES);
      good_frame(cfg_reg[CSR_QUAT_KIND], 16'h1111, 16'h2222, 16'h3333, 16'h4444);
   endtask

   task test_unknown_kind();
      good_frame(8'h00, 16'h9999, 16'h9999, 16'h9999, 16'h9999);
      good_frame(8'hFF, 16'h7777, 16'h7777, 16'h7777, 16'h7777);
      good_frame(cfg_reg[CSR_QUAT_KIND], 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00);
   endtask

   // extreme and shared register values, plus writes past the last register
   task test_register_settings();
      load_registers(8'h00, 8'hFF, 8'h80, 8'h01, 8'h00);
      good_frame(8'hFF, 16'h0A0A, 16'h0B0B, 16'h0C0C, 16'h0D0D);
      good_frame(8'h00, 16'h1000, 16'h2000, 16'h3000, 16'h4000);
      load_registers(8'hFF, 8'h42, 8'h42, 8'h42, 8'h43);
      good_frame(8'h42, 16'h1357, 16'h2468, 16'h7531, 16'h0000);
      good_frame(8'h43, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
      settle();
      csr_write(CSR_ACCEL_KIND, 8'h10);
      good_frame(8'h42, 16'hABCD, 16'hBCDE, 16'hCDEF, 16'h0000);
      good_frame(8'h43, 16'h0005, 16'h0006, 16'h0007, 16'h0008);
      settle();
      for (int idx = CSR_QUAT_KIND + 1; idx < 8; idx++) begin
         csr_write(idx[CSR_INDEX_WIDTH-1:0], 8'hFF);
      end
      good_frame(8'h43, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001);
      load_defaults();
   endtask

   function automatic logic [15:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return 16'h8000;
      end else if (r < 20) begin
         return 16'h7FFF;
      end else if (r < 27) begin
         return 16'hFFFF;
      end else if (r < 34) begin
         return 16'h0000;
      end
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   task random_frame(inout int phase_bytes);
      logic [7:0]       kind;
      logic [3:0][15:0] words;
      logic [7:0]       delta;
      int               cut;
      int               r;
      quiet_mode = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
         kind = cfg_reg[CSR_QUAT_KIND];
      end else if (r < 55) begin
         kind = cfg_reg[CSR_ACCEL_KIND];
      end else if (r < 70) begin
         kind = cfg_reg[CSR_RATE_KIND];
      end else if (r < 85) begin
         kind = cfg_reg[CSR_ANGLE_KIND];
      end else begin
         kind = 8'($urandom_range(0, 255));
      end
      for (int k = 0; k < 4; k++) begin
         words[k] = pick_value();
      end
      delta = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      send_frame(kind, words, delta, cut);
      phase_bytes += cut;
   endtask

   task test_random_traffic();
      int phase_bytes;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
            2: begin
               load_registers(8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFE);
            end
            3: begin
               load_defaults();
            end
            default: begin
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            random_frame(phase_bytes);
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      stall_left  = 0;
      quiet_mode  = 1'b0;
      reset_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_record();
      test_value_extremes();
      test_sync_in_frame();
      test_bad_checksum();
      test_unknown_kind();
      test_register_settings();
      test_random_traffic();
      settle();

      if (expected_words.size() != 0) begin
         report_mismatch($sformatf("%0d record words never arrived", expected_words.size()));
      end
      $display("Sent %0d bytes in %0d whole frames, %0d of them quaternion frames.",
               bytes_sent, frames_sent, quat_frames_sent);
      $display("Checked %0d record words against %0d predicted; %0d mismatches.",
               words_checked, words_predicted, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
